/* rtl/mtwm_pkg.sv */
// Shared types, character codes and helper functions for the text width meter.
// Depends on nothing; the glyph table, the pen controller and the top level import it.
`default_nettype none

package mtwm_pkg;

  localparam int unsigned GLYPH_W       = 16;
  localparam int unsigned PEN_W         = 32;
  localparam int unsigned SUM_W         = 34;
  localparam int unsigned CODE_W        = 15;
  localparam int unsigned CODE_VALUE_MAX = 32767;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 24;

  // Character codes the parser looks at.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_CTRL3 = 8'd3;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_1     = 8'd49;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_H_UP  = 8'd72;
  localparam logic [7:0] CH_H_LO  = 8'd104;
  localparam logic [7:0] CH_J_UP  = 8'd74;
  localparam logic [7:0] CH_J_LO  = 8'd106;
  localparam logic [7:0] CH_K_UP  = 8'd75;
  localparam logic [7:0] CH_K_LO  = 8'd107;
  localparam logic [7:0] CH_L_UP  = 8'd76;
  localparam logic [7:0] CH_L_LO  = 8'd108;
  localparam logic [7:0] CH_N_UP  = 8'd78;
  localparam logic [7:0] CH_N_LO  = 8'd110;
  localparam logic [7:0] CH_U_UP  = 8'd85;
  localparam logic [7:0] CH_U_LO  = 8'd117;
  localparam logic [7:0] CH_V_UP  = 8'd86;
  localparam logic [7:0] CH_V_LO  = 8'd118;
  localparam logic [7:0] CH_W_UP  = 8'd87;
  localparam logic [7:0] CH_W_LO  = 8'd119;
  localparam logic [7:0] CH_Y_UP  = 8'd89;
  localparam logic [7:0] CH_Y_LO  = 8'd121;
  localparam logic [7:0] CH_Z_UP  = 8'd90;
  localparam logic [7:0] CH_Z_LO  = 8'd122;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_TILDE  = 2'd1,
    PH_CODE   = 2'd2,
    PH_CTRL   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SG_NONE  = 2'd0,
    SG_PLUS  = 2'd1,
    SG_MINUS = 2'd2
  } sign_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LARGE = 3'd0,
    CFG_START_KERN  = 3'd1,
    CFG_SMALL_SCALE = 3'd2,
    CFG_LARGE_SCALE = 3'd3,
    CFG_SMALL_ADV   = 3'd4,
    CFG_LARGE_ADV   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        start_large;
    logic        start_kern;
    logic [15:0] small_scale;
    logic [15:0] large_scale;
    logic [23:0] small_adv;
    logic [23:0] large_adv;
  } cfg_t;

  // Clamp a wide signed sum to the signed 32-bit pen range.
  function automatic logic signed [PEN_W-1:0] sat_pen(input logic signed [SUM_W-1:0] v);
    logic signed [PEN_W-1:0] r;
    if (v > SUM_W'(signed'(32'h7fff_ffff))) begin
      r = 32'sh7fff_ffff;
    end else if (v < -SUM_W'(signed'(35'sh8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[PEN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic sat_hit(input logic signed [SUM_W-1:0] v);
    return (v[SUM_W-1:PEN_W-1] != '0) && (v[SUM_W-1:PEN_W-1] != '1);
  endfunction

endpackage

`default_nettype wire

/* rtl/mtwm_in_if.sv */
// Input channel of the text width meter: one text byte or one glyph width load.
// Stand-alone interface, no package dependency.
`default_nettype none

interface mtwm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  text_byte;
  logic        load_large_font;
  logic [15:0] glyph_width;

  modport source (output valid, func, text_byte, load_large_font, glyph_width, input ready);
  modport sink   (input valid, func, text_byte, load_large_font, glyph_width, output ready);
endinterface

`default_nettype wire

/* rtl/mtwm_out_if.sv */
// Output channel of the text width meter: the measured string width.
// Stand-alone interface, no package dependency.
`default_nettype none

interface mtwm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] width_x;
  logic               width_saturated;

  modport source (output valid, width_x, width_saturated, input ready);
  modport sink   (input valid, width_x, width_saturated, output ready);
endinterface

`default_nettype wire

/* rtl/mtwm_glyph_ram.sv */
// Glyph width table: one write port, two registered read ports.
// Uses mtwm_pkg for the entry width.
`default_nettype none

module mtwm_glyph_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic [mtwm_pkg::GLYPH_W-1:0]    wdata_i,
  input  logic                            re_i,
  input  logic [AW-1:0]                   raddr_a_i,
  input  logic [AW-1:0]                   raddr_b_i,
  output logic [mtwm_pkg::GLYPH_W-1:0]    rdata_a_o,
  output logic [mtwm_pkg::GLYPH_W-1:0]    rdata_b_o
);
  import mtwm_pkg::*;

  logic [GLYPH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/mtwm_pen_ctrl.sv */
// Markup parser and pen accumulator: applies one measured byte per cycle while step_i is set.
// Uses mtwm_pkg for codes, phase and sign types and the saturation helpers.
`default_nettype none

module mtwm_pen_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    text_byte_i,
  input  logic [31:0]                   prod_small_i,
  input  logic [31:0]                   prod_large_i,
  input  mtwm_pkg::cfg_t                cfg_i,
  output logic                          emit_o,
  output logic signed [31:0]            width_x_o,
  output logic                          width_sat_o
);
  import mtwm_pkg::*;

  logic signed [PEN_W-1:0] pen_q, pen_d, saved_q, saved_d;
  logic                    large_q, large_d, kern_q, kern_d;
  logic                    in_str_q, in_str_d, ovf_q, ovf_d;
  phase_e                  phase_q, phase_d;
  sign_e                   sign_q, sign_d;
  logic [CODE_W-1:0]       value_q, value_d;

  logic                    eff_large, eff_kern;
  logic [PEN_W-1:0]        step;
  logic signed [SUM_W-1:0] glyph_sum, code_sum, code_base, code_off;
  logic [18:0]             acc;
  logic                    is_digit;

  // The first measured byte of a string takes the start flags.
  assign eff_large = in_str_q ? large_q : cfg_i.start_large;
  assign eff_kern  = in_str_q ? kern_q  : cfg_i.start_kern;

  // Glyph advance: a byte after a control byte always takes the fixed advance.
  always_comb begin
    if (eff_kern && (phase_q != PH_CTRL)) begin
      step = eff_large ? prod_large_i : prod_small_i;
    end else begin
      step = eff_large ? PEN_W'(cfg_i.large_adv) : PEN_W'(cfg_i.small_adv);
    end
  end

  assign glyph_sum = SUM_W'(pen_q) + signed'({2'b00, step});

  assign code_base = (sign_q == SG_NONE) ? '0 : SUM_W'(pen_q);
  assign code_off  = (sign_q == SG_MINUS) ? -signed'({3'b000, value_q, 16'h0000})
                                          :  signed'({3'b000, value_q, 16'h0000});
  assign code_sum  = code_base + code_off;

  assign acc      = 19'({4'b0000, value_q}) * 19'd10 + 19'(text_byte_i - CH_0);
  assign is_digit = (text_byte_i >= CH_0) && (text_byte_i <= CH_9);

  always_comb begin
    pen_d    = pen_q;
    saved_d  = saved_q;
    large_d  = large_q;
    kern_d   = kern_q;
    in_str_d = in_str_q;
    ovf_d    = ovf_q;
    phase_d  = phase_q;
    sign_d   = sign_q;
    value_d  = value_q;
    if (step_i) begin
      if (text_byte_i == CH_NUL) begin
        pen_d    = '0;
        large_d  = cfg_i.start_large;
        kern_d   = cfg_i.start_kern;
        in_str_d = 1'b0;
        ovf_d    = 1'b0;
        phase_d  = PH_NORMAL;
        sign_d   = SG_NONE;
        value_d  = '0;
      end else begin
        logic text_en;
        text_en  = 1'b0;
        large_d  = eff_large;
        kern_d   = eff_kern;
        in_str_d = 1'b1;
        case (phase_q)
          PH_TILDE: begin
            phase_d = PH_NORMAL;
            sign_d  = SG_NONE;
            value_d = '0;
            if (text_byte_i == CH_PLUS || text_byte_i == CH_MINUS) begin
              sign_d  = (text_byte_i == CH_PLUS) ? SG_PLUS : SG_MINUS;
              phase_d = PH_CODE;
            end else if (text_byte_i == CH_Y_LO || text_byte_i == CH_Y_UP) begin
              saved_d = pen_q;
            end else if (text_byte_i == CH_Z_LO || text_byte_i == CH_Z_UP) begin
              pen_d = saved_q;
            end else if (is_digit) begin
              value_d = CODE_W'(text_byte_i - CH_0);
              phase_d = PH_CODE;
            end else begin
              text_en = 1'b1;
            end
          end
          PH_CODE: begin
            phase_d = PH_NORMAL;
            sign_d  = SG_NONE;
            value_d = '0;
            case (text_byte_i)
              CH_N_LO, CH_N_UP: large_d = (value_q != '0);
              CH_K_LO, CH_K_UP: kern_d = (value_q != '0);
              CH_H_LO, CH_H_UP: begin
                pen_d = sat_pen(code_sum);
                ovf_d = ovf_q | sat_hit(code_sum);
              end
              CH_L_LO, CH_L_UP, CH_W_LO, CH_W_UP, CH_J_LO, CH_J_UP,
              CH_V_LO, CH_V_UP, CH_U_LO, CH_U_UP, CH_0: begin
                phase_d = PH_NORMAL;
              end
              default: begin
                if (text_byte_i >= CH_1 && text_byte_i <= CH_9) begin
                  // Digits 1 to 9 keep the code open and saturate the value.
                  phase_d = PH_CODE;
                  sign_d  = sign_q;
                  value_d = (acc > 19'(CODE_VALUE_MAX)) ? CODE_W'(CODE_VALUE_MAX)
                                                        : acc[CODE_W-1:0];
                end else begin
                  text_en = 1'b1;
                end
              end
            endcase
          end
          PH_CTRL: begin
            phase_d = PH_NORMAL;
            pen_d   = sat_pen(glyph_sum);
            ovf_d   = ovf_q | sat_hit(glyph_sum);
          end
          default: begin
            if (text_byte_i <= CH_CTRL3) begin
              phase_d = PH_CTRL;
            end else if (text_byte_i == CH_TILDE) begin
              phase_d = PH_TILDE;
            end else begin
              text_en = 1'b1;
            end
          end
        endcase
        if (text_en) begin
          if (text_byte_i == CH_LF || text_byte_i == CH_CR) begin
            pen_d = '0;
          end else begin
            pen_d = sat_pen(glyph_sum);
            ovf_d = ovf_q | sat_hit(glyph_sum);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q    <= '0;
      saved_q  <= '0;
      large_q  <= 1'b0;
      kern_q   <= 1'b0;
      in_str_q <= 1'b0;
      ovf_q    <= 1'b0;
      phase_q  <= PH_NORMAL;
      sign_q   <= SG_NONE;
      value_q  <= '0;
    end else begin
      pen_q    <= pen_d;
      saved_q  <= saved_d;
      large_q  <= large_d;
      kern_q   <= kern_d;
      in_str_q <= in_str_d;
      ovf_q    <= ovf_d;
      phase_q  <= phase_d;
      sign_q   <= sign_d;
      value_q  <= value_d;
    end
  end

  assign emit_o      = step_i && (text_byte_i == CH_NUL);
  assign width_x_o   = pen_q;
  assign width_sat_o = ovf_q;

endmodule

`default_nettype wire

/* rtl/markup_text_width_meter.sv */
// Path: an accepted terminating byte 0 passes the stage 1 and stage 2 registers, then loads the output register.
// Throughput: one byte per cycle; the input stalls only while a second terminating byte
// sits in the last stage and the previous width has not been taken.
// Reset: parser, pen and configuration registers return to their reset values at once;
// the glyph width table has no reset and must be loaded before it is used.
// Uses mtwm_pkg, mtwm_in_if, mtwm_out_if, mtwm_glyph_ram and mtwm_pen_ctrl.
`default_nettype none

module markup_text_width_meter #(
  parameter int unsigned GLYPHS_PER_FONT = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mtwm_in_if.sink                           in_i,
  mtwm_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [mtwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtwm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mtwm_pkg::*;

  // The table holds both fonts: small glyphs first, large glyphs after them.
  localparam int unsigned DEPTH = 2 * GLYPHS_PER_FONT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = $clog2(GLYPHS_PER_FONT);

  // Pipeline overview:
  //   stage 0 (accept): glyph table is written by loads and read for both fonts.
  //   stage 1: table data is multiplied by the two kerning scales.
  //   stage 2: the parser and pen accumulator apply the byte; byte 0 loads the
  //            output register.
  // Table reads and writes both happen at acceptance, in transaction order,
  // so a load is always visible to the next byte and no forwarding is needed.
  // The font is picked only in stage 2, because the preceding byte may change it.

  cfg_t cfg_q;

  logic              s1_valid_q, s1_func_q, s2_valid_q, s2_func_q;
  logic [7:0]        s1_byte_q, s2_byte_q;
  logic [31:0]       prod_small_q, prod_large_q;
  logic [GLYPH_W-1:0] rd_small, rd_large;

  logic              advance, accept, step;
  logic [IW-1:0]     gidx;
  logic [AW-1:0]     addr_small, addr_large;

  logic              emit;
  logic signed [31:0] width_x;
  logic              width_sat;

  logic              out_valid_q, out_valid_d;
  logic signed [31:0] out_width_q;
  logic              out_sat_q;

  // Only a terminating byte needs the output register, so only that case can
  // hold up the pipeline.
  assign advance = !(s2_valid_q && !s2_func_q && (s2_byte_q == CH_NUL) &&
                     out_valid_q && !out_o.ready);
  assign accept  = in_i.valid && advance;
  assign in_i.ready = advance;

  // Glyph index is the byte reduced modulo the font size; the byte is below
  // twice the font size, so a single compare and subtract does it.
  always_comb begin
    if ({1'b0, in_i.text_byte} >= 9'(GLYPHS_PER_FONT)) begin
      gidx = IW'(in_i.text_byte - 8'(GLYPHS_PER_FONT));
    end else begin
      gidx = IW'(in_i.text_byte);
    end
  end

  assign addr_small = AW'(gidx);
  assign addr_large = AW'(gidx) + AW'(GLYPHS_PER_FONT);

  mtwm_glyph_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_glyph_ram (
    .clk_i     (clk_i),
    .we_i      (accept && in_i.func),
    .waddr_i   (in_i.load_large_font ? addr_large : addr_small),
    .wdata_i   (in_i.glyph_width),
    .re_i      (advance),
    .raddr_a_i (addr_small),
    .raddr_b_i (addr_large),
    .rdata_a_o (rd_small),
    .rdata_b_o (rd_large)
  );

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_large <= 1'b0;
      cfg_q.start_kern  <= 1'b0;
      cfg_q.small_scale <= 16'd256;
      cfg_q.large_scale <= 16'd256;
      cfg_q.small_adv   <= 24'h08_0000;
      cfg_q.large_adv   <= 24'h10_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_LARGE: cfg_q.start_large <= cfg_data_i[0];
        CFG_START_KERN:  cfg_q.start_kern  <= cfg_data_i[0];
        CFG_SMALL_SCALE: cfg_q.small_scale <= cfg_data_i[15:0];
        CFG_LARGE_SCALE: cfg_q.large_scale <= cfg_data_i[15:0];
        CFG_SMALL_ADV:   cfg_q.small_adv   <= cfg_data_i;
        CFG_LARGE_ADV:   cfg_q.large_adv   <= cfg_data_i;
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  // Pipeline control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Pipeline payload. Both products are formed; the Q8.8 width times the Q8.8
  // scale is already the Q16.16 kerned advance.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_func_q    <= in_i.func;
      s1_byte_q    <= in_i.text_byte;
      s2_func_q    <= s1_func_q;
      s2_byte_q    <= s1_byte_q;
      prod_small_q <= 32'(rd_small) * 32'(cfg_q.small_scale);
      prod_large_q <= 32'(rd_large) * 32'(cfg_q.large_scale);
    end
  end

  assign step = advance && s2_valid_q && !s2_func_q;

  mtwm_pen_ctrl u_pen_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .text_byte_i  (s2_byte_q),
    .prod_small_i (prod_small_q),
    .prod_large_i (prod_large_q),
    .cfg_i        (cfg_q),
    .emit_o       (emit),
    .width_x_o    (width_x),
    .width_sat_o  (width_sat)
  );

  // Output register: takes a new width whenever it is empty or being drained.
  assign out_valid_d = emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_width_q <= width_x;
      out_sat_q   <= width_sat;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.width_x         = out_width_q;
  assign out_o.width_saturated = out_sat_q;

endmodule

`default_nettype wire
